/* src/assert_macros.svh */
// Assertion macros shared by the RTL.
// Each checks a property on the rising edge of clk while reset is released.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: lbl");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* src/esd_pkg.sv */
// ----------------------------------------------------------------------------
// esd_pkg
// Types and constants of the escape-stuffing deframer.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam logic [7:0]  ESC_CODE      = 8'h1b;
    localparam logic [7:0]  EOT_CODE      = 8'h04;
    localparam logic [31:0] CAPACITY_INIT = 32'hFFFF_FFFF;
    localparam logic [1:0]  HDR_LAST_IDX  = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_BODY    = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_END      = 2'd1,
        KIND_TOO_LONG = 2'd2,
        KIND_OVERRUN  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        kind_t       kind;
        logic [31:0] msg_count;
        logic        last;
    } result_t;

endpackage

/* src/esd_in_stage.sv */
// ----------------------------------------------------------------------------
// esd_in_stage
// Input register: holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module esd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_axis_tready = !valid_reg || byte_take;
    assign valid_next    = (s_axis_tvalid && s_axis_tready) || (valid_reg && !byte_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            data_reg <= s_axis_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

/* src/esd_decode.sv */
// ----------------------------------------------------------------------------
// esd_decode
// Deframer state: header gathering, length check, unescaping, discard.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esd_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output esd_pkg::result_t  res
);

    logic [31:0]      capacity_reg;
    esd_pkg::phase_t  phase_reg;
    esd_pkg::phase_t  phase_next;
    logic [1:0]       hdr_idx_reg;
    logic [1:0]       hdr_idx_next;
    logic [31:0]      length_reg;
    logic [31:0]      length_next;
    logic             esc_reg;
    logic             esc_next;
    logic [31:0]      count_reg;
    logic [31:0]      count_next;
    logic [31:0]      len_shift;
    logic             is_esc;
    logic             is_eot;

    assign len_shift = {length_reg[23:0], rx_byte};
    assign is_esc    = (rx_byte == esd_pkg::ESC_CODE);
    assign is_eot    = (rx_byte == esd_pkg::EOT_CODE);

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        length_next   = length_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        res_valid     = 1'b0;
        res.data_byte = 8'h00;
        res.kind      = esd_pkg::KIND_DATA;
        res.msg_count = 32'd0;
        res.last      = 1'b0;

        if (step)
        begin
            unique case (phase_reg)
                esd_pkg::PH_BODY:
                begin
                    esc_next = 1'b0;
                    if (!esc_reg && is_esc)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (!esc_reg && is_eot)
                    begin
                        res_valid     = 1'b1;
                        res.kind      = esd_pkg::KIND_END;
                        res.msg_count = count_reg;
                        res.last      = 1'b1;
                        phase_next    = esd_pkg::PH_HEADER;
                        length_next   = 32'd0;
                        count_next    = 32'd0;
                    end
                    else if (count_reg >= length_reg)
                    begin
                        res_valid     = 1'b1;
                        res.kind      = esd_pkg::KIND_OVERRUN;
                        res.msg_count = count_reg;
                        res.last      = 1'b1;
                        phase_next    = esd_pkg::PH_HEADER;
                        length_next   = 32'd0;
                        count_next    = 32'd0;
                    end
                    else
                    begin
                        count_next    = count_reg + 32'd1;
                        res_valid     = 1'b1;
                        res.data_byte = rx_byte;
                        res.msg_count = count_reg + 32'd1;
                    end
                end
                esd_pkg::PH_DISCARD:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (is_eot)
                    begin
                        phase_next  = esd_pkg::PH_HEADER;
                        length_next = 32'd0;
                        count_next  = 32'd0;
                    end
                    else if (is_esc)
                    begin
                        esc_next = 1'b1;
                    end
                end
                default:
                begin
                    // header phase; the unused code behaves the same
                    phase_next  = esd_pkg::PH_HEADER;
                    length_next = len_shift;
                    if (hdr_idx_reg != esd_pkg::HDR_LAST_IDX)
                    begin
                        hdr_idx_next = hdr_idx_reg + 2'd1;
                    end
                    else
                    begin
                        hdr_idx_next = 2'd0;
                        esc_next     = 1'b0;
                        count_next   = 32'd0;
                        // capacity must hold length plus the end marker
                        if (capacity_reg <= len_shift)
                        begin
                            phase_next = esd_pkg::PH_DISCARD;
                            res_valid  = 1'b1;
                            res.kind   = esd_pkg::KIND_TOO_LONG;
                            res.last   = 1'b1;
                        end
                        else
                        begin
                            phase_next = esd_pkg::PH_BODY;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= esd_pkg::CAPACITY_INIT;
            phase_reg    <= esd_pkg::PH_HEADER;
            hdr_idx_reg  <= 2'd0;
            length_reg   <= 32'd0;
            esc_reg      <= 1'b0;
            count_reg    <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            length_reg  <= length_next;
            esc_reg     <= esc_next;
            count_reg   <= count_next;
        end
    end

    // header index only advances while in the header phase
    `ASSERT_NEVER(a_hdr_idx_phase, clk, rst_n, (hdr_idx_reg != 2'd0) && (phase_reg != esd_pkg::PH_HEADER))
    // no escape carried across into a header
    `ASSERT_NEVER(a_esc_in_header, clk, rst_n, esc_reg && (phase_reg == esd_pkg::PH_HEADER))
    // body never decodes more bytes than the header allowed
    `ASSERT_NEVER(a_count_bound, clk, rst_n, (phase_reg == esd_pkg::PH_BODY) && (count_reg > length_reg))
    // a too-long report always leads into discard
    `ASSERT_PROP(a_too_long_discard, clk, rst_n, (res_valid && (res.kind == esd_pkg::KIND_TOO_LONG)) |=> (phase_reg == esd_pkg::PH_DISCARD))

endmodule

/* src/esd_out_stage.sv */
// ----------------------------------------------------------------------------
// esd_out_stage
// Result register: holds one decoded beat until the sink takes it.
// ----------------------------------------------------------------------------
module esd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  esd_pkg::result_t  res,
    output logic              load_ok,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // [7:0] data_byte, [39:8] msg_count
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    output logic              m_axis_tlast
);

    logic              valid_reg;
    esd_pkg::result_t  res_reg;

    assign load_ok = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {res_reg.msg_count, res_reg.data_byte};
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;

endmodule

/* src/escape_stuffing_deframer.sv */
// An input beat is registered, decoded, and its result registered on the output.
// Throughput: one byte per cycle; the decoder advances whenever the result register
//   is empty or being drained, so a stalled sink stops intake after one buffered byte.
// Reset (rst_n, async, active low): header phase, counters cleared, buffer
//   capacity set to 0xFFFFFFFF, both pipeline registers empty.
// ----------------------------------------------------------------------------
// escape_stuffing_deframer
// Length-header, ESC/EOT byte-stuffing deframer with buffer size check.
// ----------------------------------------------------------------------------
module escape_stuffing_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,     // buffer_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [7:0] data_byte, [39:8] msg_count
    output logic [1:0]  m_axis_tuser,    // [1:0] kind
    output logic        m_axis_tlast
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              load_ok;
    logic              step;
    logic              res_valid;
    esd_pkg::result_t  res;

    assign step = byte_valid && load_ok;

    esd_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data),
        .byte_take     (step)
    );

    esd_decode u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .rx_byte     (byte_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    esd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .load_ok       (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* sim/escape_stuffing_deframer_tb.sv */
// ----------------------------------------------------------------------------
// escape_stuffing_deframer_tb
// Self-checking bench for the length-header, ESC/EOT byte-stuffing deframer.
// A short directed table hits the corners first: zero length, extreme data,
// escaped codes, overrun, and an all-ones length with a discard. Random frames
// follow under several buffer capacities. Every accepted output beat is checked
// against a typed table result or a cycle-free predictor of the decoder, fed by
// accepted input beats. Input bursts and output stalls are randomized.
// ----------------------------------------------------------------------------
module escape_stuffing_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BEATS  = 140;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        ROW_PRED,   // checked against the predictor
        ROW_NONE,   // no result may follow this beat
        ROW_RES     // result typed in the table
    } row_mode_t;

    typedef struct {
        logic [7:0] b;
        row_mode_t  md;
        result_t    ex;
    } dir_row_t;

    typedef struct {
        phase_t      ph;
        logic [1:0]  hdr_idx;
        logic [31:0] len;
        logic        esc;
        logic [31:0] cnt;
        logic [31:0] cap;
    } deframe_state_t;

    localparam result_t NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // bench-side sideband, driven together with tdata
    row_mode_t   drv_mode = ROW_PRED;
    result_t     drv_exp = '0;

    deframe_state_t gen_st;   // tracks framing for the stimulus generator
    deframe_state_t chk_st;   // advanced on accepted beats only
    result_t        pending_results[$];

    int          errors = 0;
    int          beats_sent = 0;
    int          results_seen = 0;
    int          kind_seen[4] = '{0, 0, 0, 0};
    int          cap_settings = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    int unsigned sink_cyc = 0;
    int unsigned sink_hold = 0;

    escape_stuffing_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_frame(inout deframe_state_t st);
        st.ph      = PH_HEADER;
        st.hdr_idx = '0;
        st.len     = '0;
        st.esc     = 1'b0;
        st.cnt     = '0;
    endfunction

    // One received byte through the decoder; returns 1 when a result comes out.
    function automatic bit deframe_byte(inout deframe_state_t st, input logic [7:0] b,
                                        output result_t r);
        logic lit;
        r = NO_RES;
        if (st.ph == PH_BODY)
        begin
            lit    = st.esc;
            st.esc = 1'b0;
            if (!lit && b == ESC_CODE)
            begin
                st.esc = 1'b1;
                return 1'b0;
            end
            if (!lit && b == EOT_CODE)
            begin
                r.kind      = KIND_END;
                r.msg_count = st.cnt;
                r.last      = 1'b1;
                restart_frame(st);
                return 1'b1;
            end
            if (st.cnt >= st.len)
            begin
                r.kind      = KIND_OVERRUN;
                r.msg_count = st.cnt;
                r.last      = 1'b1;
                restart_frame(st);
                return 1'b1;
            end
            st.cnt      = st.cnt + 32'd1;
            r.data_byte = b;
            r.msg_count = st.cnt;
            return 1'b1;
        end
        if (st.ph == PH_DISCARD)
        begin
            if (st.esc)
                st.esc = 1'b0;
            else if (b == EOT_CODE)
                restart_frame(st);
            else if (b == ESC_CODE)
                st.esc = 1'b1;
            return 1'b0;
        end
        st.ph  = PH_HEADER;
        st.len = {st.len[23:0], b};
        if (st.hdr_idx != HDR_LAST_IDX)
        begin
            st.hdr_idx = st.hdr_idx + 2'd1;
            return 1'b0;
        end
        st.hdr_idx = '0;
        st.esc     = 1'b0;
        st.cnt     = '0;
        // capacity must cover length plus the end marker
        if (st.cap <= st.len)
        begin
            st.ph  = PH_DISCARD;
            r.kind = KIND_TOO_LONG;
            r.last = 1'b1;
            return 1'b1;
        end
        st.ph = PH_BODY;
        return 1'b0;
    endfunction

    task automatic report(input string what, input result_t want, input result_t got);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("[%0t] %s", $time, what);
            $display("    expected data %02h kind %0d count %0d last %0d",
                     want.data_byte, want.kind, want.msg_count, want.last);
            $display("    got      data %02h kind %0d count %0d last %0d",
                     got.data_byte, got.kind, got.msg_count, got.last);
        end
    endtask

    // Output check first, then prediction of the beat taken at this edge.
    always @(posedge clk)
    begin : result_mon
        result_t got;
        result_t want;
        result_t pred;
        bit      hit;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.data_byte = m_axis_tdata[7:0];
                got.msg_count = m_axis_tdata[39:8];
                got.kind      = kind_t'(m_axis_tuser);
                got.last      = m_axis_tlast;
                results_seen++;
                kind_seen[int'(got.kind)]++;
                if (pending_results.size() == 0)
                    report("result with nothing expected", NO_RES, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.data_byte !== want.data_byte || got.kind !== want.kind ||
                        got.msg_count !== want.msg_count || got.last !== want.last)
                        report("mismatch", want, got);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                hit = deframe_byte(chk_st, s_axis_tdata, pred);
                case (drv_mode)
                    ROW_PRED: if (hit) pending_results.push_back(pred);
                    ROW_RES:  pending_results.push_back(drv_exp);
                    default:  ;
                endcase
            end
        end
    end

    // Sink: always ready, coin flips, one-in-four, then long stalls.
    always @(posedge clk)
    begin
        sink_cyc <= sink_cyc + 1;
        case (sink_cyc[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (sink_cyc[1:0] == 2'd0);
            default:
            begin
                if (sink_hold != 0)
                begin
                    m_axis_tready <= 1'b0;
                    sink_hold     <= sink_hold - 1;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        sink_hold <= $urandom_range(5, 30);
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("run stopped: cycle limit reached, %0d results still expected",
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input row_mode_t md, input result_t ex);
        result_t scratch;
        int      gap;
        void'(deframe_byte(gen_st, b, scratch));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        drv_mode      <= md;
        drv_exp       <= ex;
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 96)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(b, ROW_PRED, NO_RES);
    endtask

    // Payload byte as it goes on the wire: codes escaped, sometimes others too.
    task automatic send_payload(input logic [7:0] b);
        if (b == ESC_CODE || b == EOT_CODE || $urandom_range(0, 15) == 0)
            send_byte(ESC_CODE);
        send_byte(b);
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0:       return ESC_CODE;
            1:       return EOT_CODE;
            default: return 8'($urandom);
        endcase
    endfunction

    // Bring the link back to a frame boundary after noise or a broken frame.
    task automatic resync();
        while (!(gen_st.ph == PH_HEADER && gen_st.hdr_idx == 2'd0))
        begin
            if (gen_st.esc || gen_st.ph == PH_HEADER)
                send_byte(8'($urandom));
            else
                send_byte(EOT_CODE);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        // let the monitor log the beat taken at the last edge
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        gen_st.cap = v;
        chk_st.cap = v;
        cap_settings++;
    endtask

    task automatic send_frame();
        logic [31:0] len;
        int          n;
        int          v;
        case ($urandom_range(0, 9))
            0:       len = gen_st.cap;
            1:       len = gen_st.cap - 32'd1;
            2:       len = $urandom;
            3:       len = 32'hFFFF_FFFF;
            default: len = $urandom_range(0, 12);
        endcase
        for (int i = 3; i >= 0; i--)
            send_byte(len[8*i +: 8]);
        n = (len > 32'd12) ? 12 : int'(len);
        if (gen_st.ph == PH_DISCARD)
        begin
            repeat ($urandom_range(0, 8)) send_payload(pick_payload());
            send_byte(EOT_CODE);
        end
        else
        begin
            v = $urandom_range(0, 19);
            if (v < 14)
            begin
                repeat (n) send_payload(pick_payload());
                send_byte(EOT_CODE);
            end
            else if (v < 17)
            begin
                repeat ($urandom_range(0, n)) send_payload(pick_payload());
                send_byte(EOT_CODE);
            end
            else if (v < 19 && len <= 32'd12)
                // one decoded byte too many
                repeat (n + 1) send_payload(pick_payload());
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
        resync();
    endtask

    initial
    begin : stim
        dir_row_t    dir_tab [23];
        logic [31:0] cap_list [7];
        int          phase_end;

        restart_frame(gen_st);
        restart_frame(chk_st);
        gen_st.cap = 32'hFFFF_FFFF;
        chk_st.cap = 32'hFFFF_FFFF;

        dir_tab = '{
            // zero length: immediate end
            '{8'h00, ROW_NONE, NO_RES}, '{8'h00, ROW_NONE, NO_RES},
            '{8'h00, ROW_NONE, NO_RES}, '{8'h00, ROW_NONE, NO_RES},
            '{EOT_CODE, ROW_RES, '{8'h00, KIND_END, 32'd0, 1'b1}},
            // length 3: extreme data, escaped ESC and EOT, then overrun
            '{8'h00, ROW_NONE, NO_RES}, '{8'h00, ROW_NONE, NO_RES},
            '{8'h00, ROW_NONE, NO_RES}, '{8'h03, ROW_NONE, NO_RES},
            '{8'hFF, ROW_RES, '{8'hFF, KIND_DATA, 32'd1, 1'b0}},
            '{ESC_CODE, ROW_NONE, NO_RES},
            '{ESC_CODE, ROW_RES, '{ESC_CODE, KIND_DATA, 32'd2, 1'b0}},
            '{ESC_CODE, ROW_NONE, NO_RES},
            '{EOT_CODE, ROW_RES, '{EOT_CODE, KIND_DATA, 32'd3, 1'b0}},
            '{8'h00, ROW_RES, '{8'h00, KIND_OVERRUN, 32'd3, 1'b1}},
            // all-ones length never fits, then a discard with an escaped EOT
            '{8'hFF, ROW_NONE, NO_RES}, '{8'hFF, ROW_NONE, NO_RES},
            '{8'hFF, ROW_NONE, NO_RES},
            '{8'hFF, ROW_RES, '{8'h00, KIND_TOO_LONG, 32'd0, 1'b1}},
            '{ESC_CODE, ROW_PRED, NO_RES}, '{EOT_CODE, ROW_PRED, NO_RES},
            '{8'h7F, ROW_PRED, NO_RES}, '{EOT_CODE, ROW_PRED, NO_RES}
        };

        cap_list = '{32'd0, 32'd1, 32'd4, 32'($urandom_range(2, 16)), 32'($urandom),
                     32'hFFFF_FFFF, 32'd13};

        burst_left = $urandom_range(1, 24);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_beat(dir_tab[i].b, dir_tab[i].md, dir_tab[i].ex);

        foreach (cap_list[p])
        begin
            write_capacity(cap_list[p]);
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
                send_frame();
        end

        wait_idle();

        $display("covered %0d input beats and %0d results over %0d capacity settings",
                 beats_sent, results_seen, cap_settings);
        $display("results by kind: data %0d, end %0d, too long %0d, overrun %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
